>>> sv/fisr_pkg.sv
// ---------------------------------------------------------------------------
// fisr_pkg
// Shared constants, types and binary32 arithmetic helpers for the fast
// reciprocal square root pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fisr_pkg;

   localparam logic [31:0] MAGIC_GUESS   = 32'h5f375a86;
   localparam logic [31:0] HALF_BITS     = 32'h3f000000;
   localparam logic [31:0] ONE_HALF_BITS = 32'h3fc00000;
   localparam logic [31:0] QNAN_BITS     = 32'hffc00000;
   localparam logic [31:0] QUIET_BIT     = 32'h00400000;
   localparam logic [30:0] INF_MAG       = 31'h7f800000;
   localparam int          NUM_STAGES    = 10;

   // Unrounded operation result: value = mag * 2^scale, or a ready special code
   typedef struct packed {
      logic               special;
      logic [31:0]        special_bits;
      logic               sign;
      logic [47:0]        mag;
      logic signed [11:0] scale;
   } fop_type;

   // Multiply front half: unpack, exact significand product, special cases
   function automatic fop_type f_mul_pre(input logic [31:0] a, input logic [31:0] b);
      fop_type    r;
      logic [7:0] ea;
      logic [7:0] eb;
      logic [23:0] sa;
      logic [23:0] sb;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      sa     = {(a[30:23] != 8'd0), a[22:0]};
      sb     = {(b[30:23] != 8'd0), b[22:0]};
      a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      r.sign  = a[31] ^ b[31];
      r.mag   = {24'd0, sa} * {24'd0, sb};
      r.scale = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300;
      r.special      = 1'b1;
      r.special_bits = 32'd0;
      if (a_nan) begin
         r.special_bits = a | QUIET_BIT;
      end else if (b_nan) begin
         r.special_bits = b | QUIET_BIT;
      end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
         r.special_bits = QNAN_BITS;
      end else if (a_inf || b_inf) begin
         r.special_bits = {r.sign, INF_MAG};
      end else begin
         r.special = 1'b0;
      end
      return r;
   endfunction

   // Subtract front half (a - b): order, align with guard bits and sticky, add
   function automatic fop_type f_sub_pre(input logic [31:0] a, input logic [31:0] b);
      fop_type     r;
      logic        bs;
      logic        xs;
      logic        ys;
      logic [31:0] xb;
      logic [31:0] yb;
      logic [7:0]  ex;
      logic [7:0]  ey;
      logic [7:0]  d;
      logic [5:0]  dsh;
      logic [23:0] sx;
      logic [23:0] sy;
      logic [53:0] ext;
      logic [26:0] yal;
      logic [27:0] sum;
      logic a_nan, b_nan, a_inf, b_inf;
      bs = ~b[31];
      if (b[30:0] > a[30:0]) begin
         xb = b; xs = bs; yb = a; ys = a[31];
      end else begin
         xb = a; xs = a[31]; yb = b; ys = bs;
      end
      ex  = (xb[30:23] == 8'd0) ? 8'd1 : xb[30:23];
      ey  = (yb[30:23] == 8'd0) ? 8'd1 : yb[30:23];
      sx  = {(xb[30:23] != 8'd0), xb[22:0]};
      sy  = {(yb[30:23] != 8'd0), yb[22:0]};
      d   = ex - ey;
      dsh = (d > 8'd31) ? 6'd31 : d[5:0];
      ext = {sy, 3'b000, 27'd0} >> dsh;
      yal = ext[53:27] | {26'd0, |ext[26:0]};
      if (xs == ys) begin
         sum = {1'b0, sx, 3'b000} + {1'b0, yal};
      end else begin
         sum = {1'b0, sx, 3'b000} - {1'b0, yal};
      end
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      r.mag   = {20'd0, sum};
      r.scale = $signed({4'b0, ex}) - 12'sd153;
      r.sign  = (sum == 28'd0) ? (xs & ys) : xs;
      r.special      = 1'b1;
      r.special_bits = 32'd0;
      if (a_nan) begin
         r.special_bits = a | QUIET_BIT;
      end else if (b_nan) begin
         r.special_bits = b | QUIET_BIT;
      end else if (a_inf && b_inf && (a[31] != bs)) begin
         r.special_bits = QNAN_BITS;
      end else if (a_inf) begin
         r.special_bits = a;
      end else if (b_inf) begin
         r.special_bits = {bs, INF_MAG};
      end else begin
         r.special = 1'b0;
      end
      return r;
   endfunction

   // Back half: find the leading one, shift, round to nearest even, pack
   function automatic logic [31:0] f_post(input fop_type f);
      logic [5:0]         p;
      logic signed [11:0] e;
      logic signed [11:0] et;
      logic signed [11:0] s;
      logic signed [11:0] ns;
      logic [6:0]         rs;
      logic [95:0]        ext;
      logic [47:0]        lm;
      logic [24:0]        mant;
      logic               rb;
      logic               st;
      logic [32:0]        field;
      logic [31:0]        res;
      p = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (f.mag[i]) p = 6'(i);
      end
      e  = $signed({6'b0, p}) + f.scale + 12'sd127;
      et = (e < 12'sd1) ? 12'sd1 : e;
      s  = et - 12'sd150 - f.scale;
      ns = -s;
      if (s < 12'sd0) begin
         lm   = f.mag << ns[5:0];
         mant = lm[24:0];
         rb   = 1'b0;
         st   = 1'b0;
      end else begin
         rs   = (s > 12'sd96) ? 7'd96 : s[6:0];
         ext  = {f.mag, 48'd0} >> rs;
         mant = ext[72:48];
         rb   = ext[47];
         st   = |ext[46:0];
      end
      mant  = mant + {24'd0, rb & (st | mant[0])};
      field = ({21'd0, 12'(et - 12'sd1)} << 23) + {8'd0, mant};
      if (f.special) begin
         res = f.special_bits;
      end else if (f.mag == 48'd0) begin
         res = {f.sign, 31'd0};
      end else if (field >= {2'b0, INF_MAG}) begin
         res = {f.sign, INF_MAG};
      end else begin
         res = {f.sign, field[30:0]};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> sv/fisr_if.sv
// ---------------------------------------------------------------------------
// fisr_if
// Valid/ready stream interfaces for operands and results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fisr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;
   modport source (output valid, output value_bits, input ready);
   modport sink   (input valid, input value_bits, output ready);
endinterface

interface fisr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_bits;
   modport source (output valid, output result_bits, input ready);
   modport sink   (input valid, input result_bits, output ready);
endinterface

`default_nettype wire

>>> sv/fast_inverse_square_root.sv
// ---------------------------------------------------------------------------
// fast_inverse_square_root
// Binary32 reciprocal square root: integer guess plus one Newton step,
// every float operation rounded to nearest even.
// ---------------------------------------------------------------------------
//  channel   dir  payload              meaning
//  req_ch    in   value_bits  [31:0]   operand, binary32 bits
//  rsp_ch    out  result_bits [31:0]   approx 1/sqrt, binary32 bits
//
//  One transaction is accepted every cycle unless a result is held on rsp_ch;
//  five float operations, each a product/align stage followed by a
//  normalise/round stage, set the depth.
//  Reset clears the stage valid bits only; data registers are not reset.
//  A held result on rsp_ch freezes the whole pipeline; nothing is dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fast_inverse_square_root (
   input  wire          clock,
   input  wire          reset,
   fisr_req_if.sink     req_ch,
   fisr_rsp_if.source   rsp_ch
);
   import fisr_pkg::*;

   logic                  advance;
   logic [NUM_STAGES:1]   valid_ff;
   logic [NUM_STAGES:1]   valid_in;

   fop_type     pre1_ff, pre3_ff, pre5_ff, pre7_ff, pre9_ff;
   logic [31:0] half2_ff, t4_ff, t6_ff, s8_ff, res10_ff;
   logic [31:0] g1_ff, g2_ff, g3_ff, g4_ff, g5_ff, g6_ff, g7_ff, g8_ff;
   logic [31:0] guess_in;
   logic [31:0] asr_value;

   // Move every stage whenever the output register is free or being taken
   assign advance      = !valid_ff[NUM_STAGES] || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Integer guess from the raw operand bits
   assign asr_value = {req_ch.value_bits[31], req_ch.value_bits[31:1]};
   assign guess_in  = MAGIC_GUESS - asr_value;

   // Shift valid bits along with the data
   always_comb begin
      valid_in = {valid_ff[NUM_STAGES-1:1], req_ch.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Datapath: x*half, (x*half)*g, ((x*half)*g)*g, 1.5-t, g*s
   always_ff @(posedge clock) begin
      if (advance) begin
         pre1_ff  <= f_mul_pre(HALF_BITS, req_ch.value_bits);
         g1_ff    <= guess_in;
         half2_ff <= f_post(pre1_ff);
         g2_ff    <= g1_ff;
         pre3_ff  <= f_mul_pre(half2_ff, g2_ff);
         g3_ff    <= g2_ff;
         t4_ff    <= f_post(pre3_ff);
         g4_ff    <= g3_ff;
         pre5_ff  <= f_mul_pre(t4_ff, g4_ff);
         g5_ff    <= g4_ff;
         t6_ff    <= f_post(pre5_ff);
         g6_ff    <= g5_ff;
         pre7_ff  <= f_sub_pre(ONE_HALF_BITS, t6_ff);
         g7_ff    <= g6_ff;
         s8_ff    <= f_post(pre7_ff);
         g8_ff    <= g7_ff;
         pre9_ff  <= f_mul_pre(g8_ff, s8_ff);
         res10_ff <= f_post(pre9_ff);
      end
   end

   assign rsp_ch.valid       = valid_ff[NUM_STAGES];
   assign rsp_ch.result_bits = res10_ff;

   // Checks
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("operand taken while output stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> valid_ff[1])
      else $error("accepted transaction missing from first stage");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff[NUM_STAGES]) |-> $past(valid_ff[NUM_STAGES-1]))
      else $error("result appeared without a transaction behind it");

endmodule

`default_nettype wire
